/* design/sat_pkg.sv */
// Shared types and constants for the slot allocator with owner map.
// Depends on nothing; imported by sat_core and slot_allocator_with_owner_map.
package sat_pkg;

  localparam int SLOT_COUNT   = 16;
  localparam int TASK_ID_BITS = 16;

  // Widths derived from the pool size.
  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  // Fixed field widths of the ports.
  localparam int OP_W     = 2;
  localparam int ID_W     = 16;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int FREE_W   = 5;
  localparam int CFG_W    = 5;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // Opcodes.
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOCATE  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_HELD = 3'd4;

  // Register word index.
  localparam logic [PADDR_W-3:0] REG_SLOTS_IN_USE = 1'b0;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic            task_present;
    logic [ID_W-1:0] task_id;
  } sat_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [FREE_W-1:0]   free_count;
  } sat_result_t;

endpackage

/* design/slot_allocator_with_owner_map.sv */
// Top level of the slot allocator: channel registers, APB register, slot table.
// Depends on sat_pkg and sat_core.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_opcode, in_task_present, in_task_id
//   out_     output     out_valid/out_stall  out_status, out_slot, out_free_count
//   cfg      APB slave  psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// One word per cycle is sustained while out_stall stays low; an accepted word
// waits in the input register while the slot table compare and first-free
// search run, and enters the result register once that register is free.
// Reset clears the busy bits and the pool size; no clearing pass is needed.
// When out_stall holds the result, the input register keeps one more word and
// in_stall rises only once that register is full as well.
module slot_allocator_with_owner_map (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sat_pkg::OP_W-1:0]      in_opcode,
  input  logic                          in_task_present,
  input  logic [sat_pkg::ID_W-1:0]      in_task_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sat_pkg::STATUS_W-1:0]  out_status,
  output logic [sat_pkg::SLOT_W-1:0]    out_slot,
  output logic [sat_pkg::FREE_W-1:0]    out_free_count,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sat_pkg::PADDR_W-1:0]   paddr,
  input  logic [sat_pkg::PDATA_W-1:0]   pwdata,
  output logic [sat_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import sat_pkg::*;

  logic              s1_valid_r;
  sat_req_t          s1_req_r;
  logic              out_valid_r;
  sat_result_t       out_res_r;
  sat_result_t       core_res;
  logic [CFG_W-1:0]  cfg_slots_r;
  logic [CNT_W-1:0]  pool_size;
  logic              out_free;
  logic              s1_adv;
  logic              in_load;
  logic              cfg_wr;
  logic              reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_SLOTS_IN_USE);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? PDATA_W'(cfg_slots_r) : '0;

  // Pool size saturates at the number of physical slots.
  assign pool_size = (int'(cfg_slots_r) > SLOT_COUNT) ? CNT_W'(SLOT_COUNT)
                                                       : CNT_W'(cfg_slots_r);

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_slots_r <= '0;
    end else begin
      if (in_load) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        cfg_slots_r <= pwdata[CFG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      s1_req_r.opcode       <= in_opcode;
      s1_req_r.task_present <= in_task_present;
      s1_req_r.task_id      <= in_task_id;
    end
    if (s1_adv) begin
      out_res_r <= core_res;
    end
  end

  sat_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_fire   (s1_adv),
    .req        (s1_req_r),
    .pool_clear (cfg_wr),
    .pool_size  (pool_size),
    .result     (core_res)
  );

  assign out_valid      = out_valid_r;
  assign out_status     = out_res_r.status;
  assign out_slot       = out_res_r.slot;
  assign out_free_count = out_res_r.free_count;

  a_err_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.status != ST_OK)) |-> (out_res_r.slot == '0))
    else $error("failed request carries a nonzero slot");

  a_free_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (CNT_W'(out_res_r.free_count) <= pool_size))
    else $error("free count exceeds pool size");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled while a stage is empty");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_res_r)))
    else $error("stalled result changed");

endmodule

/* design/sat_core.sv */
// Slot table: busy bits, owner IDs, owner match and first-free search.
// Computes one request per cycle while req_fire is high and updates the table at the same edge.
// Depends on sat_pkg.
module sat_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       req_fire,
  input  sat_pkg::sat_req_t          req,
  input  logic                       pool_clear,
  input  logic [sat_pkg::CNT_W-1:0]  pool_size,
  output sat_pkg::sat_result_t       result
);
  import sat_pkg::*;

  logic [SLOT_COUNT-1:0]   busy_r;
  logic [SLOT_COUNT-1:0]   busy_nxt;
  logic [TASK_ID_BITS-1:0] owner_r [SLOT_COUNT];
  logic [CNT_W-1:0]        busy_cnt_r;
  logic [CNT_W-1:0]        busy_cnt_nxt;

  logic [TASK_ID_BITS-1:0] req_id;
  logic [SLOT_COUNT-1:0]   match_vec;
  logic [SLOT_COUNT-1:0]   free_vec;
  logic [SLOT_COUNT-1:0]   first_free;
  logic [SLOT_COUNT-1:0]   pool_mask;
  logic [IDX_W-1:0]        hit_idx;
  logic [IDX_W-1:0]        alloc_idx;
  logic                    hit;
  logic                    any_free;
  logic                    do_alloc;
  logic                    do_release;
  logic [STATUS_W-1:0]     status;
  logic [IDX_W-1:0]        slot_idx;

  assign req_id = TASK_ID_BITS'(req.task_id);

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      pool_mask[i] = (CNT_W'(i) < pool_size);
      match_vec[i] = busy_r[i] && (owner_r[i] == req_id);
      free_vec[i]  = !busy_r[i] && pool_mask[i];
    end
  end

  // Isolate the lowest set bit of the free vector.
  assign first_free = free_vec & (~free_vec + SLOT_COUNT'(1));
  assign hit        = |match_vec;
  assign any_free   = |free_vec;

  // A task holds at most one slot, and first_free is one-hot, so OR-ing
  // the indices of the set bits gives the encoded position.
  always_comb begin
    hit_idx   = '0;
    alloc_idx = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (match_vec[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
      if (first_free[i]) begin
        alloc_idx = alloc_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    status     = ST_OK;
    slot_idx   = '0;
    do_alloc   = 1'b0;
    do_release = 1'b0;
    case (req.opcode)
      OP_ALLOC: begin
        if (!req.task_present) begin
          status = ST_ABSENT;
        end else if (hit) begin
          status = ST_DUP;
        end else if (!any_free) begin
          status = ST_FULL;
        end else begin
          slot_idx = alloc_idx;
          do_alloc = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (!req.task_present) begin
          status = ST_ABSENT;
        end else if (!hit) begin
          status = ST_NOT_HELD;
        end else begin
          slot_idx   = hit_idx;
          do_release = 1'b1;
        end
      end
      default: begin
        // Locate; the unused opcode behaves the same way.
        if (req.task_present && hit) begin
          slot_idx = hit_idx;
        end else begin
          status = ST_NOT_HELD;
        end
      end
    endcase
  end

  always_comb begin
    busy_nxt     = busy_r;
    busy_cnt_nxt = busy_cnt_r;
    if (do_alloc) begin
      busy_nxt     = busy_r | first_free;
      busy_cnt_nxt = busy_cnt_r + CNT_W'(1);
    end else if (do_release) begin
      busy_nxt     = busy_r & ~match_vec;
      busy_cnt_nxt = busy_cnt_r - CNT_W'(1);
    end
  end

  assign result.status     = status;
  assign result.slot       = SLOT_W'(slot_idx);
  assign result.free_count = FREE_W'(pool_size - busy_cnt_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= '0;
      busy_cnt_r <= '0;
    end else if (pool_clear) begin
      busy_r     <= '0;
      busy_cnt_r <= '0;
    end else if (req_fire) begin
      busy_r     <= busy_nxt;
      busy_cnt_r <= busy_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire && do_alloc) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (first_free[i]) begin
          owner_r[i] <= req_id;
        end
      end
    end
  end

  a_cnt_matches_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(busy_r) == int'(busy_cnt_r))
    else $error("busy count disagrees with busy bits");

  a_busy_within_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r & ~pool_mask) == '0)
    else $error("slot outside the pool is marked busy");

  a_single_owner: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("task holds more than one slot");

endmodule

/* tb/slot_allocator_with_owner_map_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for slot_allocator_with_owner_map: a mirror of the slot table
// predicts every reply word, and random idling and stalls run on both channels.
// Depends on sat_pkg and the design files only.
module slot_allocator_with_owner_map_tb;
  import sat_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int QUIET_LIMIT  = 2000;
  localparam int LONG_HOLD    = 60;
  localparam int SETTLE       = 6;
  localparam int ID_SET_SIZE  = 20;

  class slot_pool_mirror;
    int unsigned     pool_len;
    bit              busy[SLOT_COUNT];
    logic [ID_W-1:0] owner[SLOT_COUNT];
    sat_result_t     pending_replies[$];
    int unsigned     failures;

    function new();
      pool_len = 0;
      failures = 0;
      foreach (busy[i]) begin
        busy[i]  = 1'b0;
        owner[i] = '0;
      end
    endfunction

    function void set_pool(logic [CFG_W-1:0] v);
      pool_len = (v > SLOT_COUNT) ? SLOT_COUNT : v;
      foreach (busy[i]) begin
        busy[i]  = 1'b0;
        owner[i] = '0;
      end
    endfunction

    function int owner_slot(logic [ID_W-1:0] id);
      int pos;
      pos = -1;
      for (int i = 0; i < pool_len; i++)
        if (pos < 0 && busy[i] && owner[i] == id)
          pos = i;
      return pos;
    endfunction

    function int unsigned free_total();
      int unsigned n;
      n = 0;
      for (int i = 0; i < pool_len; i++)
        if (!busy[i])
          n++;
      return n;
    endfunction

    function int unsigned pending();
      return pending_replies.size();
    endfunction

    function void take_request(logic [OP_W-1:0] op, logic pres, logic [ID_W-1:0] id);
      sat_result_t r;
      int pos;
      r.status = ST_OK;
      r.slot   = '0;
      pos = pres ? owner_slot(id) : -1;
      case (op)
        OP_ALLOC: begin
          if (!pres) begin
            r.status = ST_ABSENT;
          end else if (pos >= 0) begin
            r.status = ST_DUP;
          end else begin
            r.status = ST_FULL;
            for (int i = 0; i < pool_len; i++) begin
              if (r.status == ST_FULL && !busy[i]) begin
                busy[i]  = 1'b1;
                owner[i] = id;
                r.status = ST_OK;
                r.slot   = SLOT_W'(i);
              end
            end
          end
        end
        OP_RELEASE: begin
          if (!pres) begin
            r.status = ST_ABSENT;
          end else if (pos < 0) begin
            r.status = ST_NOT_HELD;
          end else begin
            busy[pos] = 1'b0;
            r.slot    = SLOT_W'(pos);
          end
        end
        default: begin
          // The spare opcode behaves as locate.
          if (pos < 0)
            r.status = ST_NOT_HELD;
          else
            r.slot = SLOT_W'(pos);
        end
      endcase
      r.free_count = FREE_W'(free_total());
      pending_replies.push_back(r);
    endfunction

    function void match_reply(sat_result_t got);
      sat_result_t want;
      if (pending_replies.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: reply word with none outstanding: status %0d slot %0d free %0d",
                   $realtime, got.status, got.slot, got.free_count);
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status || got.slot !== want.slot ||
          got.free_count !== want.free_count) begin
        failures++;
        if (failures <= 10)
          $display("%0t: mismatch: status %0d/%0d slot %0d/%0d free %0d/%0d (want/got)",
                   $realtime, want.status, got.status, want.slot, got.slot,
                   want.free_count, got.free_count);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [OP_W-1:0]    in_opcode;
  logic               in_task_present;
  logic [ID_W-1:0]    in_task_id;
  logic               out_valid;
  logic               out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]  out_slot;
  logic [FREE_W-1:0]  out_free_count;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  slot_pool_mirror mirror = new();
  bit              calm;
  bit              hold_request;
  int unsigned     quiet_cycles;
  logic [ID_W-1:0] id_set[ID_SET_SIZE];

  slot_allocator_with_owner_map dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_task_present(in_task_present), .in_task_id(in_task_id),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_slot(out_slot), .out_free_count(out_free_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Reply side: random stall bursts, plus one long hold on request.
  initial begin : reply_sink
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 20) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Both handshakes are sampled here, on values from before the edge.
  always @(posedge clk) begin
    sat_result_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.status     = out_status;
        got.slot       = out_slot;
        got.free_count = out_free_count;
        mirror.match_reply(got);
      end
      if (in_valid && !in_stall)
        mirror.take_request(in_opcode, in_task_present, in_task_id);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_word(logic [OP_W-1:0] op, logic pres, logic [ID_W-1:0] id);
    if (!calm && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_task_present <= pres;
    in_task_id      <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (mirror.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_pool_size(logic [CFG_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_SLOTS_IN_USE, 2'b00};
    pwdata  <= PDATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    mirror.set_pool(v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_phase(logic [CFG_W-1:0] pool, int unsigned n, int unsigned alloc_pct);
    int unsigned     r;
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] id;
    write_pool_size(pool);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct)
        op = OP_ALLOC;
      else if (r < alloc_pct + (100 - alloc_pct) / 2)
        op = OP_RELEASE;
      else if (r < 95)
        op = OP_LOCATE;
      else
        op = OP_SPARE;
      // Mostly a small set of tasks, so that releases and lookups find owners.
      if ($urandom_range(0, 9) == 0)
        id = ID_W'($urandom);
      else
        id = id_set[$urandom_range(0, ID_SET_SIZE - 1)];
      send_word(op, $urandom_range(0, 19) != 0, id);
    end
    wait_drained();
  endtask

  initial begin
    calm            = 1'b0;
    hold_request    = 1'b0;
    quiet_cycles    = 0;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_opcode       <= OP_ALLOC;
    in_task_present <= 1'b0;
    in_task_id      <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    foreach (id_set[i])
      id_set[i] = ID_W'($urandom);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Pool size is zero out of reset, so allocation reports a full pool.
    send_word(OP_ALLOC, 1'b1, 16'h0001);
    send_word(OP_LOCATE, 1'b1, 16'h0001);
    wait_drained();

    write_pool_size(5'd2);
    send_word(OP_ALLOC, 1'b0, 16'hFFFF);
    send_word(OP_ALLOC, 1'b1, 16'h0000);
    send_word(OP_ALLOC, 1'b1, 16'hFFFF);
    send_word(OP_ALLOC, 1'b1, 16'h1234);
    send_word(OP_ALLOC, 1'b1, 16'hFFFF);
    send_word(OP_LOCATE, 1'b1, 16'hFFFF);
    send_word(OP_LOCATE, 1'b0, 16'hFFFF);
    send_word(OP_RELEASE, 1'b0, 16'h0000);
    send_word(OP_RELEASE, 1'b1, 16'h5555);
    send_word(OP_SPARE, 1'b1, 16'h0000);
    send_word(OP_RELEASE, 1'b1, 16'h0000);
    send_word(OP_LOCATE, 1'b1, 16'h0000);
    send_word(OP_ALLOC, 1'b1, 16'hABCD);
    send_word(OP_RELEASE, 1'b1, 16'hFFFF);
    send_word(OP_RELEASE, 1'b1, 16'hFFFF);
    send_word(OP_RELEASE, 1'b1, 16'hABCD);
    wait_drained();

    random_phase(5'd16, 70, 60);
    random_phase(5'd31, 55, 45);
    random_phase(5'd3, 45, 40);
    random_phase(5'd1, 30, 40);
    random_phase(5'd0, 15, 40);
    // The reply side holds off long enough for the input to back up.
    hold_request = 1'b1;
    random_phase(5'd8, 60, 45);
    random_phase(5'd16, 50, 55);
    // Same size again: the write still clears every slot.
    calm = 1'b1;
    random_phase(5'd16, 90, 50);

    repeat (8) @(posedge clk);
    if (mirror.failures == 0 && mirror.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
